>>> sv/hkt_pkg.sv
// ----------------------------------------------------------------------------
// hkt_pkg
// Shared types, codes and hash functions for the hashed key table.
// ----------------------------------------------------------------------------
package hkt_pkg;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_ZERO = 2'd2,
        ST_FULL = 2'd3
    } st_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FIN,
        S_DIV,
        S_HEAD,
        S_RD,
        S_CHK,
        S_APPEND,
        S_LINK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clr;
        logic fold;
        logic start;
        logic div_step;
        logic set_head;
        logic rd;
        logic follow;
        logic wr_head;
        logic append;
        logic link;
        logic set_st;
        st_t  st;
        logic found;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic last;
        logic is_ins;
        logic zero_val;
        logic cur_valid;
        logic hash_match;
        logic chain_end;
        logic pool_full;
        logic div_done;
        logic out_free;
    } stat_t;

    localparam int unsigned DivSteps = 32;

    function automatic logic [31:0] fold_byte(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] t;
        t = h + {24'd0, b};
        t = t + (t << 10);
        t = t ^ (t >> 6);
        return t;
    endfunction

    function automatic logic [31:0] finalize(input logic [31:0] h);
        logic [31:0] t;
        t = h + (h << 3);
        t = t ^ (t >> 11);
        t = t + (t << 15);
        return t;
    endfunction

endpackage

>>> sv/hkt_ram.sv
// ----------------------------------------------------------------------------
// hkt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> sv/hkt_ctrl.sv
// ----------------------------------------------------------------------------
// hkt_ctrl
// Sequencer: head clear sweep, byte accept, modulo, chain walk, write-back.
// ----------------------------------------------------------------------------
module hkt_ctrl import hkt_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (stat.clr_done) state_next = S_IDLE;
            S_IDLE:   if (in_valid && stat.last) state_next = S_FIN;
            S_FIN:    state_next = S_DIV;
            S_DIV:    if (stat.div_done) state_next = S_HEAD;
            S_HEAD:   state_next = S_RD;
            S_RD:     state_next = S_CHK;
            S_CHK:
            begin
                if (stat.is_ins && stat.zero_val)
                    state_next = S_DONE;
                else if (!stat.cur_valid || stat.hash_match)
                    state_next = S_DONE;
                else if (stat.chain_end)
                    state_next = (stat.is_ins && !stat.pool_full) ? S_APPEND : S_DONE;
                else
                    state_next = S_RD;
            end
            S_APPEND: state_next = S_LINK;
            S_LINK:   state_next = S_DONE;
            S_DONE:   if (stat.out_free) state_next = S_IDLE;
            default:  state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.st = ST_OK;
        in_stall = (state_reg != S_IDLE);
        unique case (state_reg)
            S_CLEAR:  cmd.clr = 1'b1;
            S_IDLE:   cmd.fold = in_valid;
            S_FIN:    cmd.start = 1'b1;
            S_DIV:    cmd.div_step = 1'b1;
            S_HEAD:   cmd.set_head = 1'b1;
            S_RD:     cmd.rd = 1'b1;
            S_CHK:
            begin
                cmd.set_st = 1'b1;
                if (stat.is_ins && stat.zero_val)
                    cmd.st = ST_ZERO;
                else if (!stat.cur_valid)
                begin
                    cmd.st = stat.is_ins ? ST_OK : ST_MISS;
                    cmd.wr_head = stat.is_ins;
                end
                else if (stat.hash_match)
                begin
                    cmd.st = stat.is_ins ? ST_MISS : ST_OK;
                    cmd.found = !stat.is_ins;
                end
                else if (stat.chain_end)
                begin
                    if (!stat.is_ins)
                        cmd.st = ST_MISS;
                    else if (stat.pool_full)
                        cmd.st = ST_FULL;
                    else
                        cmd.st = ST_OK;
                end
                else
                begin
                    cmd.set_st = 1'b0;
                    cmd.follow = 1'b1;
                end
            end
            S_APPEND: cmd.append = 1'b1;
            S_LINK:   cmd.link = 1'b1;
            S_DONE:   cmd.load_out = stat.out_free;
            default:  cmd = '0;
        endcase
    end
endmodule

>>> sv/hkt_dp.sv
// ----------------------------------------------------------------------------
// hkt_dp
// Datapath: hash fold, modulo unit, entry store, pool fill, result register.
// ----------------------------------------------------------------------------
module hkt_dp import hkt_pkg::*; #(
    parameter int NUM_BUCKETS  = 256,
    parameter int POOL_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [8:0]  cfg_data,
    input  logic        op,
    input  logic [7:0]  key_byte,
    input  logic        last_byte,
    input  logic [31:0] value,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [1:0]  status,
    output logic [31:0] value_out,
    output logic [31:0] hash_code,
    input  cmd_t        cmd,
    output stat_t       stat
);
    localparam int HW  = NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1;
    localparam int SD  = NUM_BUCKETS + POOL_ENTRIES;
    localparam int AW  = $clog2(SD);
    localparam int LW  = $clog2(POOL_ENTRIES + 1);
    localparam int NBW = $clog2(NUM_BUCKETS + 1);
    localparam int EW  = 64 + LW;
    localparam int CW  = $clog2(DivSteps);

    logic [8:0]     bc_reg;
    logic [31:0]    run_reg;
    logic [31:0]    fin_reg;
    logic           op_reg;
    logic [31:0]    val_reg;
    logic [31:0]    dq_reg;
    logic [NBW-1:0] rem_reg;
    logic [CW-1:0]  cnt_reg;
    logic [AW-1:0]  idx_reg;
    logic           head_reg;
    logic [LW-1:0]  fill_reg;
    logic [HW-1:0]  clr_reg;
    logic           ov_reg;
    st_t            st_reg;
    logic [31:0]    vo_reg;
    logic [31:0]    hc_reg;
    logic [1:0]     st_next;

    logic [NBW-1:0] n_act;
    logic [NBW:0]   r2;
    logic [NBW:0]   r2_sub;

    logic           hv_we, hv_wd, hv_rd;
    logic [HW-1:0]  hv_wa;
    logic           st_we;
    logic [AW-1:0]  st_wa;
    logic [EW-1:0]  st_wd, st_rd;
    logic [31:0]    rd_hash, rd_val;
    logic [LW-1:0]  rd_link;

    assign rd_hash = st_rd[EW-1:EW-32];
    assign rd_val  = st_rd[EW-33:LW];
    assign rd_link = st_rd[LW-1:0];

    always_comb
    begin
        if (bc_reg == 9'd0)
            n_act = NBW'(1);
        else if (32'(bc_reg) > NUM_BUCKETS)
            n_act = NBW'(NUM_BUCKETS);
        else
            n_act = NBW'(bc_reg);
    end

    // Restoring remainder, one dividend bit per step
    assign r2     = {rem_reg, dq_reg[31]};
    assign r2_sub = r2 - {1'b0, n_act};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg   <= 9'd256;
            run_reg  <= '0;
            fill_reg <= '0;
            clr_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                bc_reg <= cfg_data;
            if (cmd.fold)
                run_reg <= fold_byte(run_reg, key_byte);
            else if (cmd.start)
                run_reg <= '0;
            if (cmd.append)
                fill_reg <= fill_reg + LW'(1);
            if (cmd.clr)
                clr_reg <= clr_reg + HW'(1);
            if (cmd.load_out)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    assign st_next = cmd.st;

    always_ff @(posedge clk)
    begin
        if (cmd.fold)
        begin
            op_reg  <= op;
            val_reg <= value;
        end
        if (cmd.start)
        begin
            fin_reg <= finalize(run_reg);
            dq_reg  <= finalize(run_reg);
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            dq_reg  <= {dq_reg[30:0], 1'b0};
            cnt_reg <= cnt_reg + CW'(1);
            rem_reg <= (r2 >= {1'b0, n_act}) ? NBW'(r2_sub) : NBW'(r2);
        end
        if (cmd.set_head)
        begin
            idx_reg  <= AW'(rem_reg);
            head_reg <= 1'b1;
        end
        if (cmd.follow)
        begin
            idx_reg  <= AW'(NUM_BUCKETS) + AW'(rd_link) - AW'(1);
            head_reg <= 1'b0;
        end
        if (cmd.set_st)
        begin
            st_reg <= st_t'(st_next);
            vo_reg <= cmd.found ? rd_val : 32'd0;
        end
        if (cmd.load_out)
        begin
            status    <= st_reg;
            value_out <= vo_reg;
            hash_code <= fin_reg;
        end
    end

    assign out_valid = ov_reg;

    // Head-valid store, swept to zero after reset
    always_comb
    begin
        hv_we = cmd.clr || cmd.wr_head;
        hv_wa = cmd.clr ? clr_reg : idx_reg[HW-1:0];
        hv_wd = !cmd.clr;
    end

    hkt_ram #(.WIDTH(1), .DEPTH(NUM_BUCKETS)) u_hv (
        .clk   (clk),
        .we    (hv_we),
        .waddr (hv_wa),
        .wdata (hv_wd),
        .re    (cmd.rd),
        .raddr (idx_reg[HW-1:0]),
        .rdata (hv_rd)
    );

    always_comb
    begin
        st_we = cmd.wr_head || cmd.append || cmd.link;
        st_wa = idx_reg;
        st_wd = {fin_reg, val_reg, LW'(0)};
        if (cmd.append)
            st_wa = AW'(NUM_BUCKETS) + AW'(fill_reg);
        if (cmd.link)
            st_wd = {rd_hash, rd_val, fill_reg};
    end

    hkt_ram #(.WIDTH(EW), .DEPTH(SD)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_wa),
        .wdata (st_wd),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (st_rd)
    );

    always_comb
    begin
        stat.clr_done   = (clr_reg == HW'(NUM_BUCKETS - 1));
        stat.last       = last_byte;
        stat.is_ins     = !op_reg;
        stat.zero_val   = (val_reg == 32'd0);
        stat.cur_valid  = head_reg ? hv_rd : 1'b1;
        stat.hash_match = (rd_hash == fin_reg);
        stat.chain_end  = (rd_link == '0) || (rd_link > fill_reg);
        stat.pool_full  = (fill_reg == LW'(POOL_ENTRIES));
        stat.div_done   = (cnt_reg == CW'(DivSteps - 1));
        stat.out_free   = !ov_reg || !out_stall;
    end
endmodule

>>> sv/hashed_key_table.sv
// ----------------------------------------------------------------------------
// hashed_key_table
// One-at-a-time hashed key table with chained overflow pool.
// ----------------------------------------------------------------------------
//  channel  | handshake            | beat contents
//  ---------+----------------------+--------------------------------------
//  input    | in_valid / in_stall  | op, key_byte, last_byte, value
//  output   | out_valid / out_stall| status, value_out, hash_code
//  config   | cfg_valid / cfg_ready| cfg_data = bucket_count (9 bits)
//
//  Each key byte is folded into the running hash as it is taken. A final byte
//  then passes through a finalize state, the bit-serial modulo unit, a head
//  setup state and, per chain entry visited, a store read (registered read
//  port) and a check, plus an append write and a link write for a pool append,
//  and a done state that loads the result. After reset a sweep clears the
//  bucket-head valid store; input is stalled, config writes are taken.
//  A result waiting under out_stall does not stall input by itself: the next
//  key is taken and worked through, then the block waits in its done state,
//  input stalled, until the output register frees.
// ----------------------------------------------------------------------------
module hashed_key_table import hkt_pkg::*; #(
    parameter int NUM_BUCKETS  = 256,
    parameter int POOL_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  key_byte,
    input  logic        last_byte,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] value_out,
    output logic [31:0] hash_code
);
    cmd_t  cmd;
    stat_t stat;

    // config register always writable
    assign cfg_ready = 1'b1;

    hkt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    hkt_dp #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .op        (op),
        .key_byte  (key_byte),
        .last_byte (last_byte),
        .value     (value),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .status    (status),
        .value_out (value_out),
        .hash_code (hash_code),
        .cmd       (cmd),
        .stat      (stat)
    );

    // pool append is always followed by the link write
    a_append_link: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |=> cmd.link)
        else $error("append not followed by link");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("result load lost");

    a_div_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step || cmd.rd || cmd.clr) |-> in_stall)
        else $error("input open during table work");
endmodule

>>> dv/tb_hashed_key_table.sv
// ----------------------------------------------------------------------------
// tb_hashed_key_table
// Self-checking bench: key bytes are streamed into the table. A scoreboard
// keeps its own copy of the hash, bucket heads and overflow pool, and checks
// every result beat field by field. Several bucket counts are used, extremes
// included, and one phase fills the overflow pool.
// ----------------------------------------------------------------------------
module tb_hashed_key_table;
    import hkt_pkg::*;

    localparam int HEADS      = 256;
    localparam int POOL       = 256;
    localparam int DRAIN_WAIT = 800;      // worst chain walk plus modulo unit
    localparam int CYCLE_CAP  = 4000000;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the table plus the queue of expected result beats
    // ------------------------------------------------------------------------
    typedef struct {
        st_t         st;
        logic [31:0] val;
        logic [31:0] hash;
    } table_reply_t;

    class key_table_scoreboard;
        logic [31:0]  run_hash;
        logic [8:0]   buckets;
        bit           used [HEADS+POOL];
        logic [31:0]  slot_hash [HEADS+POOL];
        logic [31:0]  slot_val [HEADS+POOL];
        int           slot_link [HEADS+POOL];
        int           pool_fill;
        table_reply_t replies [$];
        int           errors;

        function new();
            run_hash  = '0;
            buckets   = 9'd256;
            pool_fill = 0;
            errors    = 0;
            foreach (used[i])
            begin
                used[i]      = 0;
                slot_hash[i] = '0;
                slot_val[i]  = '0;
                slot_link[i] = 0;
            end
        endfunction

        function void set_buckets(logic [8:0] n);
            buckets = n;
        endfunction

        function int pending();
            return replies.size();
        endfunction

        // next entry in a chain, -1 at the end
        function int chain_next(int idx);
            if (slot_link[idx] == 0)
                return -1;
            return HEADS + slot_link[idx] - 1;
        endfunction

        function st_t insert_key(int head, logic [31:0] h, logic [31:0] v);
            int idx;
            int nx;
            int slot;
            if (v == 0)
                return ST_ZERO;
            if (!used[head])
            begin
                used[head]      = 1;
                slot_hash[head] = h;
                slot_val[head]  = v;
                slot_link[head] = 0;
                return ST_OK;
            end
            idx = head;
            while (slot_hash[idx] != h)
            begin
                nx = chain_next(idx);
                if (nx < 0 || !used[nx])
                    break;
                idx = nx;
            end
            if (slot_hash[idx] == h)
                return ST_MISS;
            if (pool_fill >= POOL)
                return ST_FULL;
            slot            = HEADS + pool_fill;
            used[slot]      = 1;
            slot_hash[slot] = h;
            slot_val[slot]  = v;
            slot_link[slot] = 0;
            pool_fill++;
            slot_link[idx]  = pool_fill;
            return ST_OK;
        endfunction

        function st_t lookup_key(int head, logic [31:0] h, output logic [31:0] found);
            int idx;
            idx   = head;
            found = '0;
            while (idx >= 0 && used[idx])
            begin
                if (slot_hash[idx] == h)
                begin
                    found = slot_val[idx];
                    return ST_OK;
                end
                idx = chain_next(idx);
            end
            return ST_MISS;
        endfunction

        // One accepted input beat
        function void note_beat(logic op_i, logic [7:0] b, logic last, logic [31:0] v);
            logic [31:0]  t;
            int           nb;
            int           head;
            table_reply_t r;
            t = run_hash + {24'd0, b};
            t = t + (t << 10);
            t = t ^ (t >> 6);
            run_hash = t;
            if (!last)
                return;
            t = t + (t << 3);
            t = t ^ (t >> 11);
            t = t + (t << 15);
            run_hash = '0;
            nb = (buckets == 0) ? 1 : (buckets > HEADS) ? HEADS : int'(buckets);
            head = int'(t % nb);
            r.hash = t;
            r.val  = '0;
            if (op_i == 1'b0)
                r.st = insert_key(head, t, v);
            else
                r.st = lookup_key(head, t, r.val);
            replies.push_back(r);
        endfunction

        // One accepted result beat
        function void check_result(logic [1:0] st, logic [31:0] v, logic [31:0] h);
            table_reply_t r;
            if (replies.size() == 0)
            begin
                $error("result beat with nothing expected: status %0d hash %h", st, h);
                errors++;
                return;
            end
            r = replies.pop_front();
            if (st !== r.st)
            begin
                $error("status: expected %0d, actual %0d", r.st, st);
                errors++;
            end
            if (v !== r.val)
            begin
                $error("value_out: expected %h, actual %h", r.val, v);
                errors++;
            end
            if (h !== r.hash)
            begin
                $error("hash_code: expected %h, actual %h", r.hash, h);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [7:0]  key_byte;
    logic        last_byte;
    logic [31:0] value;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [31:0] hash_code;

    hashed_key_table #(
        .NUM_BUCKETS  (HEADS),
        .POOL_ENTRIES (POOL)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .key_byte  (key_byte),
        .last_byte (last_byte),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .value_out (value_out),
        .hash_code (hash_code)
    );

    key_table_scoreboard sb = new();

    // keys kept for reuse, so lookups hit and inserts collide
    typedef struct {
        logic [31:0] bytes;
        int          len;
    } stored_key_t;

    stored_key_t known_keys [$];
    int          cycles;
    int          results_seen;
    int          out_hold;
    bit          long_hold_done;
    bit          send_quiet;     // stretch with no sender gaps
    bit          recv_quiet;     // stretch with no receiver stalls

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Cycle cap; a hang anywhere ends here
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_CAP)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side. Signals are sampled at the falling edge: inputs only move
    // at the rising edge, so what is seen here is what the next edge takes.
    // ------------------------------------------------------------------------
    initial
    begin
        results_seen   = 0;
        out_hold       = 0;
        long_hold_done = 0;
        recv_quiet     = 0;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                sb.check_result(status, value_out, hash_code);
                results_seen++;
                if (results_seen % 64 == 0)
                    recv_quiet = ($urandom_range(0, 3) == 0);
                // one long hold-off so the block backs up and stalls input
                if (results_seen == 60 && !long_hold_done)
                begin
                    out_hold       = 3000;
                    long_hold_done = 1;
                end
                else
                    out_hold = recv_quiet ? 0 : $urandom_range(0, 5);
            end
        end
    end

    // Stall driver: picks up the hold length after each result beat and
    // counts it down here
    initial
    begin
        int hold_left;
        int seen_prev;
        hold_left = 0;
        seen_prev = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (results_seen != seen_prev)
            begin
                seen_prev = results_seen;
                hold_left = out_hold;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Input side. Each task returns at a rising edge with in_valid still high,
    // so the next beat either drops it or overwrites it once.
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic o, input logic [7:0] b, input logic l,
                             input logic [31:0] v);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= o;
        key_byte  <= b;
        last_byte <= l;
        value     <= v;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        sb.note_beat(o, b, l, v);
        @(posedge clk);
    endtask

    // Non-final beats carry random op and value; the block ignores them there
    task automatic send_key(input logic o, input logic [31:0] kb, input int len,
                            input logic [31:0] v);
        for (int i = 0; i < len; i++)
        begin
            if (i == len - 1)
                send_beat(o, kb[8*i +: 8], 1'b1, v);
            else
                send_beat(1'($urandom), kb[8*i +: 8], 1'b0, $urandom);
        end
    endtask

    // Idle point: drop valid, let all results come back, let the walk settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_buckets(input logic [8:0] n);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        sb.set_buckets(n);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    // Random traffic: mostly well-formed keys, a share reused to hit
    // existing entries, zero and all-ones values mixed in
    task automatic run_phase(input int beats, input int max_len, input int ins_pct);
        int          sent;
        int          n;
        logic        o;
        logic [31:0] kb;
        logic [31:0] v;
        stored_key_t k;
        sent = 0;
        while (sent < beats)
        begin
            if (known_keys.size() > 0 && $urandom_range(0, 99) < 40)
            begin
                k  = known_keys[$urandom_range(0, known_keys.size() - 1)];
                kb = k.bytes;
                n  = k.len;
            end
            else
            begin
                n = $urandom_range(1, max_len);
                for (int i = 0; i < 4; i++)
                    kb[8*i +: 8] = pick_byte();
                k.bytes = kb;
                k.len   = n;
                known_keys.push_back(k);
            end
            o = ($urandom_range(0, 99) < ins_pct) ? 1'b0 : 1'b1;
            case ($urandom_range(0, 9))
                0:       v = 32'd0;
                1:       v = 32'hffff_ffff;
                default: v = $urandom;
            endcase
            if (sent % 50 == 0)
                send_quiet = ($urandom_range(0, 3) == 0);
            send_key(o, kb, n, v);
            sent += n;
        end
        send_quiet = 0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        op         = 1'b0;
        key_byte   = '0;
        last_byte  = 1'b0;
        value      = '0;
        send_quiet = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes, both ops, duplicate, zero value, misses
        write_buckets(9'd256);
        send_key(1'b1, 32'h0000_0041, 1, 32'h1234_5678);   // lookup on empty table
        send_key(1'b0, 32'h0000_0041, 1, 32'hffff_ffff);   // insert
        send_key(1'b1, 32'h0000_0041, 1, 32'h0);           // found
        send_key(1'b0, 32'h0000_0041, 1, 32'h0000_0001);   // duplicate hash
        send_key(1'b0, 32'h0000_0042, 1, 32'h0);           // zero value rejected
        send_key(1'b1, 32'h0000_0042, 1, 32'h0);           // still absent
        send_key(1'b0, 32'h0000_0000, 1, 32'h8000_0000);   // all-zero byte
        send_key(1'b0, 32'h0000_00ff, 1, 32'h7fff_ffff);   // all-ones byte
        send_key(1'b0, 32'hffff_ffff, 4, 32'h5555_5555);
        send_key(1'b0, 32'h0000_0000, 4, 32'haaaa_aaaa);
        send_key(1'b1, 32'h0000_0000, 1, 32'h0);
        send_key(1'b1, 32'h0000_00ff, 1, 32'h0);
        send_key(1'b1, 32'hffff_ffff, 4, 32'h0);
        send_key(1'b1, 32'h0000_0000, 4, 32'h0);
        drain();

        // Few buckets: chains and collisions in the pool
        write_buckets(9'd13);
        run_phase(500, 4, 60);
        drain();

        // Bucket count changed with entries held: some lookups now miss
        write_buckets(9'd256);
        run_phase(300, 4, 50);
        drain();

        // One bucket: every insert chains, pool runs out
        write_buckets(9'd1);
        run_phase(800, 2, 80);
        drain();

        // Zero is taken as one bucket
        write_buckets(9'd0);
        run_phase(150, 3, 50);
        drain();

        // Above the head count saturates
        write_buckets(9'd511);
        run_phase(150, 4, 50);
        drain();

        write_buckets(9'd100);
        run_phase(100, 4, 50);
        drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
